// ----- design/axis_autorepeat_controller_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the axis auto-repeat controller
// Each macro expands to a clocked concurrent assertion. It expands to nothing
// when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef AXIS_AUTOREPEAT_CONTROLLER_CORE_DEFINES_SVH
`define AXIS_AUTOREPEAT_CONTROLLER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define AAC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition must never be seen outside reset.
`define AAC_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define AAC_ASSERT(label, clk, rst_n, prop)
`define AAC_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ----- design/aac_pkg.sv -----
// ----------------------------------------------------------------------------
// aac_pkg
// Shared types and constants for the axis auto-repeat controller.
// ----------------------------------------------------------------------------
`default_nettype none

package aac_pkg;

    localparam int THRESHOLD_BITS = 15;
    localparam int MS_BITS        = 16;
    localparam int AXIS_BITS      = 16;
    localparam int CFG_INDEX_BITS = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AXIS_THRESHOLD     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INITIAL_DELAY_MS   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_INTERVAL_MS = 2'd2;

    // Reset values of the configuration registers
    localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET       = 15'd20000;
    localparam logic [MS_BITS-1:0]        INITIAL_DELAY_RESET   = 16'd400;
    localparam logic [MS_BITS-1:0]        REPEAT_INTERVAL_RESET = 16'd135;

    // Item opcodes
    localparam logic OP_AXIS_EVENT = 1'b0;
    localparam logic OP_TICK       = 1'b1;

    // Only this axis drives the key state
    localparam logic [7:0] ACTIVE_AXIS = 8'd0;

    typedef struct packed {
        logic [THRESHOLD_BITS-1:0] axis_threshold;
        logic [MS_BITS-1:0]        initial_delay_ms;
        logic [MS_BITS-1:0]        repeat_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic left_pressed;
        logic right_pressed;
        logic left_first;
        logic right_first;
    } flags_t;

    typedef struct packed {
        logic left_held;
        logic right_held;
        logic left_repeat;
        logic right_repeat;
    } result_t;

endpackage

`default_nettype wire

// ----- design/aac_step.sv -----
// ----------------------------------------------------------------------------
// aac_step
// Next-state and result logic for one axis event or time tick.
// ----------------------------------------------------------------------------
`default_nettype none

module aac_step #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic                            operation,
    input  wire logic [7:0]                      axis_index,
    input  wire logic signed [15:0]              axis_value,
    input  wire logic [15:0]                     elapsed_ms,
    input  wire aac_pkg::cfg_t                   cfg,
    input  wire aac_pkg::flags_t                 flags,
    input  wire logic signed [15:0]              prev_axis,
    input  wire logic [TIMER_BITS-1:0]           timer,
    output aac_pkg::flags_t                      flags_next,
    output logic signed [15:0]                   prev_axis_next,
    output logic [TIMER_BITS-1:0]                timer_next,
    output aac_pkg::result_t                     result
);
    import aac_pkg::*;

    localparam int SUM_BITS = ((TIMER_BITS > MS_BITS) ? TIMER_BITS : MS_BITS) + 1;
    localparam logic [SUM_BITS-1:0] TIMER_MAX = SUM_BITS'({TIMER_BITS{1'b1}});

    logic signed [16:0]    pos_th;
    logic signed [16:0]    neg_th;
    logic signed [16:0]    pv;
    logic signed [16:0]    nv;
    logic [SUM_BITS-1:0]   timer_sum;
    logic [TIMER_BITS-1:0] timer_sat;
    logic [MS_BITS-1:0]    limit;
    logic                  fire;

    assign pos_th = signed'({2'b00, cfg.axis_threshold});
    assign neg_th = -pos_th;
    assign pv     = 17'(prev_axis);
    assign nv     = 17'(axis_value);

    assign timer_sum = SUM_BITS'(timer) + SUM_BITS'(elapsed_ms);
    assign timer_sat = (timer_sum > TIMER_MAX) ? {TIMER_BITS{1'b1}}
                                               : timer_sum[TIMER_BITS-1:0];
    assign limit     = (flags.left_first || flags.right_first) ? cfg.initial_delay_ms
                                                               : cfg.repeat_interval_ms;
    assign fire      = SUM_BITS'(timer_sat) >= SUM_BITS'(limit);

    always_comb
    begin
        flags_next     = flags;
        prev_axis_next = prev_axis;
        timer_next     = timer;
        result         = '0;

        if (operation == OP_AXIS_EVENT)
        begin
            if (axis_index == ACTIVE_AXIS)
            begin
                if (pv <= pos_th && nv > pos_th)
                begin
                    flags_next.right_pressed = 1'b1;
                    flags_next.right_first   = 1'b1;
                end
                if (pv > pos_th && nv <= pos_th)
                begin
                    flags_next.right_pressed = 1'b0;
                    flags_next.right_first   = 1'b0;
                end
                if (pv > neg_th && nv <= neg_th)
                begin
                    flags_next.left_pressed = 1'b1;
                    flags_next.left_first   = 1'b1;
                end
                if (pv <= neg_th && nv > neg_th)
                begin
                    flags_next.left_pressed = 1'b0;
                    flags_next.left_first   = 1'b0;
                end
                prev_axis_next = axis_value;
            end
        end
        else if (flags.left_pressed || flags.right_pressed)
        begin
            timer_next = timer_sat;
            if (fire)
            begin
                // left wins when both sides are held
                if (flags.left_pressed)
                begin
                    result.left_repeat    = 1'b1;
                    flags_next.left_first = 1'b0;
                end
                else
                begin
                    result.right_repeat    = 1'b1;
                    flags_next.right_first = 1'b0;
                end
                timer_next = '0;
            end
        end
        else
        begin
            timer_next             = '0;
            flags_next.left_first  = 1'b0;
            flags_next.right_first = 1'b0;
        end

        result.left_held  = flags_next.left_pressed;
        result.right_held = flags_next.right_pressed;
    end

endmodule

`default_nettype wire

// ----- design/axis_autorepeat_controller_core.sv -----
// ----------------------------------------------------------------------------
// axis_autorepeat_controller_core
// Typematic left/right key repeat driven by joystick axis 0 and time ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries either an axis event
//   (operation 0: axis_index, axis_value) or a time tick (operation 1:
//   elapsed_ms). Every input transfer yields exactly one result transfer on
//   the output channel (out_valid/out_ready): held flags after the item and
//   the left/right repeat pulses for a tick.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   threshold (0), initial delay (1) and repeat interval (2); it is always
//   ready and should be written while no item is in flight.
//   The result is registered at the edge that takes the item. Throughput is
//   one item per cycle while out_ready stays high, set by the single result
//   register; in_ready is high while that register is empty or being drained.
//   When the receiver stalls the result holds and in_ready drops until the
//   result is taken.
//   Reset clears all key state and the timer and loads the default
//   threshold 20000, initial delay 400 ms and repeat interval 135 ms.
// ----------------------------------------------------------------------------
`default_nettype none
`include "axis_autorepeat_controller_core_defines.svh"

module axis_autorepeat_controller_core #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               operation,
    input  wire logic [7:0]         axis_index,
    input  wire logic signed [15:0] axis_value,
    input  wire logic [15:0]        elapsed_ms,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    left_held,
    output logic                    right_held,
    output logic                    left_repeat,
    output logic                    right_repeat
);
    import aac_pkg::*;

    cfg_t                  cfg_reg;
    flags_t                flags_reg;
    flags_t                flags_next;
    logic signed [15:0]    prev_axis_reg;
    logic signed [15:0]    prev_axis_next;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;
    result_t               result_next;
    result_t               result_reg;
    logic                  out_valid_reg;
    logic                  in_xfer;
    logic                  first_orphan;
    logic                  idle_tick;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.axis_threshold     <= THRESHOLD_RESET;
            cfg_reg.initial_delay_ms   <= INITIAL_DELAY_RESET;
            cfg_reg.repeat_interval_ms <= REPEAT_INTERVAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_AXIS_THRESHOLD:
                    cfg_reg.axis_threshold <= cfg_data[THRESHOLD_BITS-1:0];
                CFG_INITIAL_DELAY_MS:
                    cfg_reg.initial_delay_ms <= cfg_data;
                CFG_REPEAT_INTERVAL_MS:
                    cfg_reg.repeat_interval_ms <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    aac_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .operation      (operation),
        .axis_index     (axis_index),
        .axis_value     (axis_value),
        .elapsed_ms     (elapsed_ms),
        .cfg            (cfg_reg),
        .flags          (flags_reg),
        .prev_axis      (prev_axis_reg),
        .timer          (timer_reg),
        .flags_next     (flags_next),
        .prev_axis_next (prev_axis_next),
        .timer_next     (timer_next),
        .result         (result_next)
    );

    // Key state advances on every input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            prev_axis_reg <= '0;
            timer_reg     <= '0;
        end
        else if (in_xfer)
        begin
            flags_reg     <= flags_next;
            prev_axis_reg <= prev_axis_next;
            timer_reg     <= timer_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_held    = result_reg.left_held;
    assign right_held   = result_reg.right_held;
    assign left_repeat  = result_reg.left_repeat;
    assign right_repeat = result_reg.right_repeat;

    // a first-press flag without its side pressed
    assign first_orphan = (flags_reg.left_first && !flags_reg.left_pressed) ||
                          (flags_reg.right_first && !flags_reg.right_pressed);
    assign idle_tick    = in_xfer && operation == OP_TICK &&
                          !flags_reg.left_pressed && !flags_reg.right_pressed;

    `AAC_ASSERT_NEVER(a_one_pulse, clk, rst_n, out_valid_reg && left_repeat && right_repeat)
    `AAC_ASSERT(a_left_pulse_held, clk, rst_n, (out_valid_reg && left_repeat) |-> left_held)
    `AAC_ASSERT(a_right_pulse_held, clk, rst_n, (out_valid_reg && right_repeat) |-> right_held)
    `AAC_ASSERT_NEVER(a_first_needs_press, clk, rst_n, first_orphan)
    `AAC_ASSERT(a_idle_tick_clears, clk, rst_n, idle_tick |=> (timer_reg == '0))

endmodule

`default_nettype wire
